>>> design/srcv_pkg.sv
// Package for the stored record CRC verifier.
// Payload structs, phase and status codes, header and CRC constants.
// No dependencies.
package srcv_pkg;

    localparam int unsigned SRCV_MAX_PAYLOAD = 4080;
    localparam int unsigned LEN_W            = 12;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd4080;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] REC_MAGIC = 32'h494F_5449;
    localparam logic [3:0]  HDR_MAGIC_LAST = 4'd3;
    localparam logic [3:0]  HDR_LAST       = 4'd15;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } srcv_phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADMAGIC = 2'd1,
        ST_TOOBIG   = 2'd2,
        ST_CRCBAD   = 2'd3
    } srcv_status_t;

    typedef enum logic [1:0] {
        HW_MAGIC   = 2'd0,
        HW_LENGTH  = 2'd1,
        HW_CRC     = 2'd2,
        HW_COUNTER = 2'd3
    } srcv_hword_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] data_byte;
    } srcv_in_t;

    typedef struct packed {
        srcv_status_t status;
        logic [31:0]  record_len;
        logic [31:0]  write_count;
        logic [31:0]  stored_crc;
        logic [31:0]  computed_crc;
    } srcv_out_t;

endpackage

>>> design/stored_record_crc_verifier_core.sv
// Channel   Dir  Handshake           Request payload
// s_        in   s_valid / s_ready   srcv_in_t  {start_req, data_byte}
// m_        out  m_valid / m_ready   srcv_out_t {status, length, counter, CRCs}
// cfg_      in   cfg_we              cfg_wdata = max_len, no wait
//
// One byte per cycle unless a full result register waits on m_ready; a verdict
// passes the input register, then the result register. The byte-wide CRC step sits between them.
// Synchronous active-low reset: parser idle, both registers empty, max_len = 4080.
// A stalled m_ready holds the result; s_ready drops only when both registers are full.
// Depends on srcv_pkg, srcv_parser, srcv_crc_byte.
module stored_record_crc_verifier_core
    import srcv_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = SRCV_MAX_PAYLOAD
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  srcv_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output srcv_out_t        m_data,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata
);

    logic             in_vld_reg, in_vld_next;
    srcv_in_t         in_data_reg;
    logic             out_vld_reg, out_vld_next;
    srcv_out_t        out_data_reg;
    logic [LEN_W-1:0] max_len_reg;
    logic             step_en;
    logic             res_valid;
    srcv_out_t        res_data;

    assign step_en = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || step_en;
    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    srcv_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .item      (in_data_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (step_en) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (step_en) begin
            out_vld_next = res_valid;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            max_len_reg <= MAX_LEN_RESET;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (step_en && res_valid) begin
            out_data_reg <= res_data;
        end
    end

`ifndef SYNTH
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_vld_reg |-> s_ready)
        else $error("input stalled while result register empty");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_vld_reg))
        else $error("result appeared without a processed byte");

    a_badmagic_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_BADMAGIC) |->
        (m_data.record_len == 32'd0 && m_data.computed_crc == 32'd0))
        else $error("bad magic result carries header data");

    a_ok_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_OK) |->
        (m_data.computed_crc == m_data.stored_crc))
        else $error("ok status with differing CRC values");
`endif

endmodule

>>> design/srcv_crc_byte.sv
// Byte-wide reflected CRC-32 update (poly 0xEDB88320).
// Depends on srcv_pkg.
module srcv_crc_byte
    import srcv_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_byte,
    output logic [31:0] crc_out
);

    always_comb begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_byte};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

>>> design/srcv_parser.sv
// Header parser, payload length tracking and verdict for one byte per step.
// Depends on srcv_pkg and srcv_crc_byte.
module srcv_parser
    import srcv_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = SRCV_MAX_PAYLOAD
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  srcv_in_t         item,
    input  logic [LEN_W-1:0] max_len,
    output logic             res_valid,
    output srcv_out_t        res_data
);

    srcv_phase_t      phase_reg, phase_next;
    logic [3:0]       hidx_reg, hidx_next;
    logic [31:0]      magic_reg, magic_next;
    logic [31:0]      len_reg, len_next;
    logic [31:0]      scrc_reg, scrc_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [31:0]      rcrc_reg, rcrc_next;

    // Values seen by this byte; a start clears the record first.
    srcv_phase_t      ph_eff;
    logic [3:0]       idx_eff;
    logic [31:0]      magic_eff, len_eff, scrc_eff, cnt_eff, rcrc_eff;
    logic [LEN_W-1:0] left_eff, left_dec;
    logic [31:0]      lane;
    logic [31:0]      magic_new, len_new, scrc_new, cnt_new;
    logic [31:0]      crc_upd, crc_fin;
    logic             bad_magic, hdr_done, too_big, empty_pl, pl_done;

    assign ph_eff    = item.start_req ? PH_HEADER : phase_reg;
    assign idx_eff   = item.start_req ? 4'd0      : hidx_reg;
    assign magic_eff = item.start_req ? 32'd0     : magic_reg;
    assign len_eff   = item.start_req ? 32'd0     : len_reg;
    assign scrc_eff  = item.start_req ? 32'd0     : scrc_reg;
    assign cnt_eff   = item.start_req ? 32'd0     : cnt_reg;
    assign rcrc_eff  = item.start_req ? ALL_ONES  : rcrc_reg;
    assign left_eff  = item.start_req ? '0        : left_reg;

    assign lane = {24'd0, item.data_byte} << {idx_eff[1:0], 3'b000};

    assign magic_new = (srcv_hword_t'(idx_eff[3:2]) == HW_MAGIC)   ? (magic_eff | lane) : magic_eff;
    assign len_new   = (srcv_hword_t'(idx_eff[3:2]) == HW_LENGTH)  ? (len_eff | lane)   : len_eff;
    assign scrc_new  = (srcv_hword_t'(idx_eff[3:2]) == HW_CRC)     ? (scrc_eff | lane)  : scrc_eff;
    assign cnt_new   = (srcv_hword_t'(idx_eff[3:2]) == HW_COUNTER) ? (cnt_eff | lane)   : cnt_eff;

    srcv_crc_byte u_crc (
        .crc_in    (rcrc_eff),
        .data_byte (item.data_byte),
        .crc_out   (crc_upd)
    );

    assign crc_fin   = crc_upd ^ ALL_ONES;
    assign left_dec  = left_eff - 1'b1;
    assign bad_magic = (idx_eff == HDR_MAGIC_LAST) && (magic_new != REC_MAGIC);
    assign hdr_done  = (idx_eff == HDR_LAST);
    assign too_big   = (len_new > {20'd0, max_len}) || (len_new > 32'(MAX_PAYLOAD));
    assign empty_pl  = (len_new[LEN_W-1:0] == '0);
    assign pl_done   = (left_dec == '0);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (step_en) begin
            unique case (ph_eff)
                PH_HEADER: begin
                    if (bad_magic) begin
                        phase_next = PH_IDLE;
                    end else if (hdr_done) begin
                        phase_next = (too_big || empty_pl) ? PH_IDLE : PH_PAYLOAD;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_PAYLOAD: phase_next = pl_done ? PH_IDLE : PH_PAYLOAD;
                PH_IDLE:    phase_next = PH_IDLE;
                default:    phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath state and result
    always_comb begin
        hidx_next  = hidx_reg;
        magic_next = magic_reg;
        len_next   = len_reg;
        scrc_next  = scrc_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        rcrc_next  = rcrc_reg;
        res_valid  = 1'b0;
        res_data   = '{status: ST_OK, record_len: 32'd0, write_count: 32'd0,
                       stored_crc: 32'd0, computed_crc: 32'd0};
        if (step_en) begin
            unique case (ph_eff)
                PH_HEADER: begin
                    hidx_next  = idx_eff + 4'd1;
                    magic_next = magic_new;
                    len_next   = len_new;
                    scrc_next  = scrc_new;
                    cnt_next   = cnt_new;
                    left_next  = left_eff;
                    rcrc_next  = rcrc_eff;
                    if (bad_magic) begin
                        res_valid       = 1'b1;
                        res_data.status = ST_BADMAGIC;
                    end else if (hdr_done) begin
                        res_data.record_len  = len_new;
                        res_data.write_count = cnt_new;
                        res_data.stored_crc  = scrc_new;
                        if (too_big) begin
                            res_valid       = 1'b1;
                            res_data.status = ST_TOOBIG;
                        end else begin
                            left_next = len_new[LEN_W-1:0];
                            rcrc_next = ALL_ONES;
                            if (empty_pl) begin
                                res_valid       = 1'b1;
                                res_data.status = (scrc_new == 32'd0) ? ST_OK : ST_CRCBAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    rcrc_next = crc_upd;
                    left_next = left_dec;
                    if (pl_done) begin
                        res_valid             = 1'b1;
                        res_data.status       = (crc_fin == scrc_reg) ? ST_OK : ST_CRCBAD;
                        res_data.record_len   = len_reg;
                        res_data.write_count  = cnt_reg;
                        res_data.stored_crc   = scrc_reg;
                        res_data.computed_crc = crc_fin;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            hidx_reg  <= 4'd0;
            magic_reg <= 32'd0;
            len_reg   <= 32'd0;
            scrc_reg  <= 32'd0;
            cnt_reg   <= 32'd0;
            left_reg  <= '0;
            rcrc_reg  <= ALL_ONES;
        end else begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            magic_reg <= magic_next;
            len_reg   <= len_next;
            scrc_reg  <= scrc_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            rcrc_reg  <= rcrc_next;
        end
    end

endmodule

>>> tb/stored_record_crc_verifier_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stored_record_crc_verifier_core: byte stream in, verdicts out.
// Depends on srcv_pkg and the verifier core; predicts each verdict and checks it in order.
module stored_record_crc_verifier_core_tb;
    import srcv_pkg::*;

    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES  = 1300;
    localparam int unsigned PHASES        = 8;
    localparam int          LONG_CUT      = 80;

    typedef enum {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_t;
    typedef logic [7:0] octet_q_t[$];

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    srcv_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    srcv_out_t        m_data;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    stored_record_crc_verifier_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // record parser mirror
    srcv_phase_t      rec_phase;
    logic [3:0]       hdr_idx;
    logic [31:0]      magic_w, len_w, crc_w, cnt_w;
    logic [11:0]      bytes_left;
    logic [31:0]      crc_run;
    logic [LEN_W-1:0] limit_len;

    srcv_out_t   verdicts_due[$];
    int unsigned failures     = 0;
    int unsigned bytes_taken  = 0;
    int unsigned src_gap_pct  = 0;
    int unsigned sink_stall_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
        c = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_of(octet_q_t p);
        logic [31:0] c;
        c = ALL_ONES;
        foreach (p[i]) c = crc32_step(c, p[i]);
        return c ^ ALL_ONES;
    endfunction

    function automatic void post_verdict(srcv_status_t st, logic [31:0] len, logic [31:0] cnt,
                                         logic [31:0] scrc, logic [31:0] ccrc);
        srcv_out_t v;
        v.status       = st;
        v.record_len   = len;
        v.write_count  = cnt;
        v.stored_crc   = scrc;
        v.computed_crc = ccrc;
        verdicts_due.push_back(v);
        rec_phase = PH_IDLE;
    endfunction

    function automatic void close_payload();
        logic [31:0] c;
        c = crc_run ^ ALL_ONES;
        post_verdict((c == crc_w) ? ST_OK : ST_CRCBAD, len_w, cnt_w, crc_w, c);
    endfunction

    // returns 1 when the byte is parsed, 0 when it falls on an idle parser
    function automatic bit parse_record_byte(srcv_in_t it);
        logic [3:0]  idx;
        logic [31:0] sh;
        if (it.start_req) begin
            rec_phase  = PH_HEADER;
            hdr_idx    = '0;
            magic_w    = '0;
            len_w      = '0;
            crc_w      = '0;
            cnt_w      = '0;
            bytes_left = '0;
            crc_run    = ALL_ONES;
        end
        case (rec_phase)
            PH_HEADER: begin
                idx = hdr_idx;
                sh  = {24'd0, it.data_byte} << (idx[1:0] * 8);
                case (idx[3:2])
                    HW_MAGIC:  magic_w |= sh;
                    HW_LENGTH: len_w   |= sh;
                    HW_CRC:    crc_w   |= sh;
                    default:   cnt_w   |= sh;
                endcase
                hdr_idx = idx + 4'd1;
                if (idx == HDR_MAGIC_LAST && magic_w != REC_MAGIC) begin
                    post_verdict(ST_BADMAGIC, '0, '0, '0, '0);
                end else if (idx == HDR_LAST) begin
                    if (len_w > {20'd0, limit_len} || len_w > SRCV_MAX_PAYLOAD) begin
                        post_verdict(ST_TOOBIG, len_w, cnt_w, crc_w, '0);
                    end else begin
                        bytes_left = len_w[11:0];
                        crc_run    = ALL_ONES;
                        if (bytes_left == '0) close_payload();
                        else rec_phase = PH_PAYLOAD;
                    end
                end
                return 1'b1;
            end
            PH_PAYLOAD: begin
                crc_run    = crc32_step(crc_run, it.data_byte);
                bytes_left = bytes_left - 12'd1;
                if (bytes_left == '0) close_payload();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin : verdict_check
        srcv_out_t want;
        if (m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %p", $time, m_data);
                failures++;
            end else begin
                want = verdicts_due.pop_front();
                cmp_field("status", {30'd0, want.status}, {30'd0, m_data.status});
                cmp_field("record_len", want.record_len, m_data.record_len);
                cmp_field("write_count", want.write_count, m_data.write_count);
                cmp_field("stored_crc", want.stored_crc, m_data.stored_crc);
                cmp_field("computed_crc", want.computed_crc, m_data.computed_crc);
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("[stored_record_crc_verifier_core] ERROR");
        $finish;
    end

    task automatic send_byte(input logic st, input logic [7:0] b);
        srcv_in_t item;
        item.start_req = st;
        item.data_byte = b;
        if ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (parse_record_byte(item)) bytes_taken++;
    endtask

    // cut > 0 sends only that many leading bytes of the record
    task automatic send_record(input logic [31:0] magic, input logic [31:0] len_field,
                               input int pay_len, input logic [31:0] crc_flip, input int cut);
        octet_q_t    pay, rec;
        logic [31:0] hdr[4];
        int          n;
        pay = {};
        for (int i = 0; i < pay_len; i++) pay.push_back(8'($urandom));
        hdr = '{magic, len_field, crc32_of(pay) ^ crc_flip, $urandom};
        rec = {};
        foreach (hdr[w]) begin
            for (int k = 0; k < 4; k++) rec.push_back(hdr[w][8*k +: 8]);
        end
        rec = {rec, pay};
        n = (cut > 0 && cut < rec.size()) ? cut : rec.size();
        for (int i = 0; i < n; i++) send_byte(i == 0, rec[i]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_len(input logic [LEN_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_len = v;
    endtask

    task automatic set_flow(input flow_t f);
        case (f)
            FLOW_SRC_IDLE:   begin src_gap_pct = 58; sink_stall_pct = 0;  end
            FLOW_SINK_STALL: begin src_gap_pct = 0;  sink_stall_pct = 58; end
            FLOW_BOTH:       begin src_gap_pct = 8;  sink_stall_pct = 8;  end
            default:         begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        endcase
    endtask

    task automatic test_header_checks();
        set_max_len(12'd4080);
        set_flow(FLOW_FREE);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_record(REC_MAGIC ^ 32'h8000_0000, 32'd0, 0, '0, 4);
        send_byte(1'b0, 8'hA5);
        send_record(REC_MAGIC ^ 32'h0000_0001, 32'd0, 0, '0, 0);
        send_record(REC_MAGIC, ALL_ONES, 0, ALL_ONES, 0);
        send_record(REC_MAGIC, 32'd4081, 0, '0, 0);
    endtask

    task automatic test_payload_crc();
        set_max_len(12'd4080);
        send_record(REC_MAGIC, 32'd0, 0, '0, 0);
        send_record(REC_MAGIC, 32'd0, 0, ALL_ONES, 0);
        send_record(REC_MAGIC, 32'd2, 2, '0, 0);
        send_record(REC_MAGIC, 32'd1, 1, 32'h0000_0001, 0);
    endtask

    task automatic test_restart();
        set_max_len(12'd4080);
        send_record(REC_MAGIC, 32'd3, 3, '0, 7);
        send_record(REC_MAGIC, 32'd0, 0, '0, 0);
        send_record(REC_MAGIC, 32'd5, 5, '0, 18);
        send_record(REC_MAGIC, 32'd1, 1, '0, 0);
    endtask

    task automatic test_length_limit();
        logic [LEN_W-1:0] r;
        set_max_len(12'd0);
        send_record(REC_MAGIC, 32'd0, 0, '0, 0);
        send_record(REC_MAGIC, 32'd1, 1, '0, 0);
        set_max_len(12'd1);
        send_record(REC_MAGIC, 32'd1, 1, '0, 0);
        send_record(REC_MAGIC, 32'd2, 2, '0, 0);
        r = 12'($urandom_range(60, 2));
        set_max_len(r);
        send_record(REC_MAGIC, {20'd0, r}, r, '0, 0);
        send_record(REC_MAGIC, {20'd0, r} + 32'd1, r + 1, '0, 0);
        set_max_len(12'd4095);
        send_record(REC_MAGIC, 32'd4081, 0, '0, 0);
    endtask

    // largest length is accepted; payload cut short, next start drops it
    task automatic test_longest_record();
        set_max_len(12'd4095);
        set_flow(FLOW_BOTH);
        send_record(REC_MAGIC, SRCV_MAX_PAYLOAD, SRCV_MAX_PAYLOAD, '0, LONG_CUT);
        send_record(REC_MAGIC, 32'd2, 2, '0, 0);
        set_flow(FLOW_FREE);
    endtask

    task automatic send_random_record();
        int unsigned kind, cap, plen;
        logic [31:0] big;
        kind = $urandom_range(99);
        cap  = (limit_len < SRCV_MAX_PAYLOAD) ? limit_len : SRCV_MAX_PAYLOAD;
        plen = $urandom_range((cap < 12) ? cap : 12, 0);
        if ($urandom_range(15) == 0) plen = $urandom_range((cap < 90) ? cap : 90, 0);
        if (kind < 60) begin
            send_record(REC_MAGIC, plen, plen, '0, 0);
        end else if (kind < 70) begin
            send_record(REC_MAGIC, plen, plen, 32'h1 << $urandom_range(31), 0);
        end else if (kind < 78) begin
            send_record(REC_MAGIC ^ (32'h1 << $urandom_range(31)), plen, plen, '0, 0);
        end else if (kind < 86) begin
            big = $urandom_range(1) ? (cap + 1 + $urandom_range(7)) : ($urandom | 32'h1000);
            send_record(REC_MAGIC, big, 0, '0, 0);
        end else if (kind < 93) begin
            send_record(REC_MAGIC, plen, plen, '0, $urandom_range(15 + plen, 1));
        end else begin
            repeat ($urandom_range(12, 1)) send_byte($urandom_range(3) == 0, 8'($urandom));
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(3, 1)) send_byte(1'b0, 8'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0] plan[PHASES];
        int unsigned      goal;
        plan = '{12'd4080, 12'd0, 12'd4095, 12'($urandom_range(4094, 2)),
                 12'd1, 12'($urandom_range(40, 2)), 12'd4080, 12'd3};
        for (int p = 0; p < PHASES; p++) begin
            set_max_len(plan[p]);
            set_flow(flow_t'(p % 4));
            goal = bytes_taken + RANDOM_BYTES / PHASES;
            while (bytes_taken < goal) send_random_record();
        end
        set_flow(FLOW_FREE);
    endtask

    initial begin
        rec_phase  = PH_IDLE;
        hdr_idx    = '0;
        magic_w    = '0;
        len_w      = '0;
        crc_w      = '0;
        cnt_w      = '0;
        bytes_left = '0;
        crc_run    = ALL_ONES;
        limit_len  = MAX_LEN_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_header_checks();
        test_payload_crc();
        test_restart();
        test_length_limit();
        test_longest_record();
        test_random_traffic();
        drain();
        if (failures == 0) begin
            $display("[stored_record_crc_verifier_core] OK");
        end else begin
            $display("[stored_record_crc_verifier_core] ERROR");
        end
        $finish;
    end

endmodule
